// ===== sv/mcg_pkg.sv =====
package mcg_pkg;

   localparam int MAX_SET       = 16;
   localparam int VALUE_BITS    = 16;
   localparam int RESULT_CAP    = 16;
   localparam int SET_CAP       = (MAX_SET < RESULT_CAP) ? MAX_SET : RESULT_CAP;
   localparam int IDX_BITS      = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
   localparam int SZ_BITS       = 5;
   localparam int ELEM_IDX_BITS = 4;
   localparam int POS_BITS      = 4;
   localparam int REQ_BITS      = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_LOAD    = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_RESTART = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_NEXT    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SET_SIZE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COMB_SIZE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALL_SIZES = 2'd2;

   localparam logic [SZ_BITS-1:0] SET_SIZE_RST  = 5'd16;
   localparam logic [SZ_BITS-1:0] COMB_SIZE_RST = 5'd1;

   // cell operations
   localparam logic [2:0] CELL_HOLD      = 3'd0;
   localparam logic [2:0] CELL_WRITE     = 3'd1;
   localparam logic [2:0] CELL_COPY      = 3'd2;
   localparam logic [2:0] CELL_LANE_SET  = 3'd3;
   localparam logic [2:0] CELL_LANE_COMB = 3'd4;
   localparam logic [2:0] CELL_SHL       = 3'd5;
   localparam logic [2:0] CELL_SHR       = 3'd6;
   localparam logic [2:0] CELL_REFILL    = 3'd7;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [2:0]               op;
      logic [ELEM_IDX_BITS-1:0] index;
      value_type                value;
      logic [SZ_BITS-1:0]       lo;
      logic [SZ_BITS-1:0]       hi;
   } cell_ctrl_type;

endpackage

// ===== sv/mcg_if.sv =====
interface mcg_req_if;
   import mcg_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [REQ_BITS-1:0]      req_type;
   logic [ELEM_IDX_BITS-1:0] elem_index;
   logic [VALUE_BITS-1:0]    elem_value;
   modport source (output valid, req_type, elem_index, elem_value, input ready);
   modport sink   (input valid, req_type, elem_index, elem_value, output ready);
endinterface

interface mcg_rsp_if;
   import mcg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] out_value;
   logic [POS_BITS-1:0]   out_position;
   logic                  last;
   logic                  done_res;
   modport source (output valid, out_value, out_position, last, done_res, input ready);
   modport sink   (input valid, out_value, out_position, last, done_res, output ready);
endinterface

// ===== sv/multiset_combination_generator_core.sv =====
// Multiset combination generator. Load transactions write the sorted set one
// element at a time, restart clears the enumeration, and each next transaction
// returns the next lexicographic combination (duplicates skipped) as one result
// per element, ascending, with last on the final one, or a single done result.
// Load, restart and the unused code give no result. The time that a next
// transaction takes is set by the chain of element cells: the aligned compare
// and the tail refill both move a lane of set values one cell per cycle, and
// results leave cell zero one per cycle while the output is ready. One
// transaction is worked on at a time.
module multiset_combination_generator_core (
   input  logic                              clock,
   input  logic                              reset,
   mcg_req_if.sink                           req_if,
   mcg_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [mcg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mcg_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mcg_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ALIGN   = 3'd1;
   localparam logic [2:0] ST_SEARCH  = 3'd2;
   localparam logic [2:0] ST_REFILL  = 3'd3;
   localparam logic [2:0] ST_LOADOUT = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [SZ_BITS-1:0] size_ff, size_in;
   logic               exhausted_ff, exhausted_in;
   logic [SZ_BITS-1:0] set_size_ff, set_size_in;
   logic [SZ_BITS-1:0] comb_size_ff, comb_size_in;
   logic               all_sizes_ff, all_sizes_in;
   logic [SZ_BITS-1:0] cnt_ff, cnt_in;
   logic [SZ_BITS-1:0] ci_ff, ci_in;
   logic [SZ_BITS-1:0] lo_ff, lo_in;
   logic [SZ_BITS-1:0] hi_ff, hi_in;
   logic [SZ_BITS-1:0] pos_ff, pos_in;
   logic               shl_ff, shl_in;
   value_type          pivot_ff, pivot_in;

   cell_ctrl_type      ctrl;
   value_type          set_val  [MAX_SET];
   value_type          comb_val [MAX_SET];
   value_type          lane_val [MAX_SET];
   logic [MAX_SET-1:0] match;

   logic [SZ_BITS-1:0] cap;
   logic [SZ_BITS-1:0] s_use;
   logic [SZ_BITS-1:0] start_size;
   logic [MAX_SET-1:0] mism;
   logic               any_mism;
   logic [SZ_BITS-1:0] ci_found;
   logic [SZ_BITS-1:0] mid;
   logic               mid_le;
   logic [SZ_BITS:0]   refill_span;
   logic               overflow;
   logic               is_last;

   // ---- cell chain
   for (genvar i = 0; i < MAX_SET; i++) begin : g_cell
      value_type upper;
      value_type lower;
      if (i == MAX_SET - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = lane_val[i+1];
      end
      if (i == 0) begin : g_bot
         assign lower = '0;
      end else begin : g_low
         assign lower = lane_val[i-1];
      end
      mcg_cell u_cell (
         .clock           (clock),
         .cell_id         (IDX_BITS'(i)),
         .ctrl            (ctrl),
         .lane_from_upper (upper),
         .lane_from_lower (lower),
         .set_val         (set_val[i]),
         .comb_val        (comb_val[i]),
         .lane_val        (lane_val[i]),
         .match           (match[i])
      );
   end

   // ---- datapath helpers
   assign cap        = SZ_BITS'(SET_CAP);
   assign s_use      = (set_size_ff > cap) ? cap : set_size_ff;
   assign start_size = all_sizes_ff ? SZ_BITS'(1) : comb_size_ff;

   // highest position below k whose element differs from its aligned set element
   always_comb begin
      ci_found = '0;
      for (int j = 0; j < MAX_SET; j++) begin
         mism[j] = !match[j] && (j < int'(size_ff));
         if (mism[j]) ci_found = SZ_BITS'(j);
      end
   end
   assign any_mism = |mism;

   assign mid         = SZ_BITS'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign mid_le      = (set_val[IDX_BITS'(mid)] <= pivot_ff);
   assign refill_span = {1'b0, lo_ff} + {1'b0, size_ff - ci_ff};
   assign overflow    = (refill_span > {1'b0, s_use});
   assign is_last     = (pos_ff == size_ff - SZ_BITS'(1));

   // ---- sequencer
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      exhausted_in = exhausted_ff;
      cnt_in       = cnt_ff;
      ci_in        = ci_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      shl_in       = shl_ff;
      pivot_in     = pivot_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.index   = req_if.elem_index;
      ctrl.value   = req_if.elem_value;
      ctrl.lo      = ci_ff;
      ctrl.hi      = size_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.req_type)
                  REQ_LOAD:    ctrl.op = CELL_WRITE;
                  REQ_RESTART: begin
                     size_in      = '0;
                     exhausted_in = 1'b0;
                  end
                  REQ_NEXT: begin
                     if (exhausted_ff) begin
                        state_in     = ST_DONE;
                        exhausted_in = 1'b1;
                     end else if (size_ff == '0) begin
                        if (start_size == '0 || start_size > s_use) begin
                           state_in     = ST_DONE;
                           exhausted_in = 1'b1;
                        end else begin
                           ctrl.op  = CELL_COPY;
                           size_in  = start_size;
                           state_in = ST_LOADOUT;
                        end
                     end else if (size_ff > s_use) begin
                        state_in     = ST_DONE;
                        exhausted_in = 1'b1;
                     end else begin
                        // align the set tail under the combination
                        ctrl.op  = CELL_LANE_SET;
                        cnt_in   = s_use - size_ff;
                        state_in = ST_ALIGN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_ALIGN: begin
            if (cnt_ff != '0) begin
               ctrl.op = CELL_SHL;
               cnt_in  = cnt_ff - SZ_BITS'(1);
            end else if (!any_mism) begin
               if (all_sizes_ff && size_ff < s_use) begin
                  ctrl.op  = CELL_COPY;
                  size_in  = size_ff + SZ_BITS'(1);
                  state_in = ST_LOADOUT;
               end else begin
                  state_in     = ST_DONE;
                  exhausted_in = 1'b1;
               end
            end else begin
               ci_in    = ci_found;
               pivot_in = comb_val[IDX_BITS'(ci_found)];
               lo_in    = '0;
               hi_in    = s_use;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               if (mid_le) lo_in = mid + SZ_BITS'(1);
               else        hi_in = mid;
            end else if (overflow) begin
               state_in     = ST_DONE;
               exhausted_in = 1'b1;
            end else begin
               // shift the set so element ni lines up with cell ci
               ctrl.op = CELL_LANE_SET;
               if (lo_ff >= ci_ff) begin
                  shl_in = 1'b1;
                  cnt_in = lo_ff - ci_ff;
               end else begin
                  shl_in = 1'b0;
                  cnt_in = ci_ff - lo_ff;
               end
               state_in = ST_REFILL;
            end
         end

         ST_REFILL: begin
            if (cnt_ff != '0) begin
               ctrl.op = shl_ff ? CELL_SHL : CELL_SHR;
               cnt_in  = cnt_ff - SZ_BITS'(1);
            end else begin
               ctrl.op  = CELL_REFILL;
               state_in = ST_LOADOUT;
            end
         end

         ST_LOADOUT: begin
            ctrl.op  = CELL_LANE_COMB;
            pos_in   = '0;
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_if.ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ctrl.op = CELL_SHL;
                  pos_in  = pos_ff + SZ_BITS'(1);
               end
            end
         end

         ST_DONE: begin
            if (rsp_if.ready) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---- configuration
   always_comb begin
      set_size_in  = set_size_ff;
      comb_size_in = comb_size_ff;
      all_sizes_in = all_sizes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SET_SIZE:  set_size_in  = SZ_BITS'(csr_wdata);
            CSR_COMB_SIZE: comb_size_in = SZ_BITS'(csr_wdata);
            CSR_ALL_SIZES: all_sizes_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         exhausted_ff <= 1'b0;
         set_size_ff  <= SET_SIZE_RST;
         comb_size_ff <= COMB_SIZE_RST;
         all_sizes_ff <= 1'b0;
         cnt_ff       <= '0;
         shl_ff       <= 1'b0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         exhausted_ff <= exhausted_in;
         set_size_ff  <= set_size_in;
         comb_size_ff <= comb_size_in;
         all_sizes_ff <= all_sizes_in;
         cnt_ff       <= cnt_in;
         shl_ff       <= shl_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff    <= ci_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pivot_ff <= pivot_in;
   end

   // ---- ports
   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = (state_ff == ST_EMIT) || (state_ff == ST_DONE);
   assign rsp_if.done_res     = (state_ff == ST_DONE);
   assign rsp_if.out_value    = (state_ff == ST_DONE) ? '0 : lane_val[0];
   assign rsp_if.out_position = (state_ff == ST_DONE) ? '0 : POS_BITS'(pos_ff);
   assign rsp_if.last         = (state_ff == ST_DONE) ? 1'b1 : is_last;

   // ---- assertions
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while a result is pending");

   a_elem_has_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.done_res) |-> (size_ff != '0 && pos_ff < size_ff))
      else $error("element result outside the current combination");

   a_done_exhausts: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.done_res) |-> exhausted_ff)
      else $error("done result without exhausted flag");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.req_type == REQ_RESTART)
      |=> (size_ff == '0 && !exhausted_ff))
      else $error("restart did not clear the enumeration");

endmodule

// ===== sv/mcg_cell.sv =====
module mcg_cell (
   input  logic                         clock,
   input  logic [mcg_pkg::IDX_BITS-1:0] cell_id,
   input  mcg_pkg::cell_ctrl_type       ctrl,
   input  mcg_pkg::value_type           lane_from_upper,
   input  mcg_pkg::value_type           lane_from_lower,
   output mcg_pkg::value_type           set_val,
   output mcg_pkg::value_type           comb_val,
   output mcg_pkg::value_type           lane_val,
   output logic                         match
);
   import mcg_pkg::*;

   localparam int CMP_BITS = IDX_BITS + SZ_BITS;

   value_type set_ff, set_in;
   value_type comb_ff, comb_in;
   value_type lane_ff, lane_in;

   logic [CMP_BITS-1:0] id_ext;
   logic [CMP_BITS-1:0] index_ext;
   logic [CMP_BITS-1:0] lo_ext;
   logic [CMP_BITS-1:0] hi_ext;

   assign id_ext    = CMP_BITS'(cell_id);
   assign index_ext = CMP_BITS'(ctrl.index);
   assign lo_ext    = CMP_BITS'(ctrl.lo);
   assign hi_ext    = CMP_BITS'(ctrl.hi);

   always_comb begin
      set_in  = set_ff;
      comb_in = comb_ff;
      lane_in = lane_ff;
      case (ctrl.op)
         CELL_WRITE: begin
            if (index_ext == id_ext) set_in = ctrl.value;
         end
         CELL_COPY:      comb_in = set_ff;
         CELL_LANE_SET:  lane_in = set_ff;
         CELL_LANE_COMB: lane_in = comb_ff;
         CELL_SHL:       lane_in = lane_from_upper;
         CELL_SHR:       lane_in = lane_from_lower;
         CELL_REFILL: begin
            // take the shifted set element only inside the tail being rebuilt
            if (id_ext >= lo_ext && id_ext < hi_ext) comb_in = lane_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff  <= set_in;
      comb_ff <= comb_in;
      lane_ff <= lane_in;
   end

   assign set_val  = set_ff;
   assign comb_val = comb_ff;
   assign lane_val = lane_ff;
   assign match    = (comb_ff == lane_ff);

endmodule

// ===== tb/mcg_comb_checker.sv =====
module mcg_comb_checker
   import mcg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [REQ_BITS-1:0]      req_type,
   input  logic [ELEM_IDX_BITS-1:0] req_elem_index,
   input  value_type                req_elem_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  value_type                rsp_out_value,
   input  logic [POS_BITS-1:0]      rsp_out_position,
   input  logic                     rsp_last,
   input  logic                     rsp_done_res,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       fail_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      value_type           value;
      logic [POS_BITS-1:0] position;
      logic                last;
      logic                done;
   } comb_elem_type;

   comb_elem_type       comb_elem_q[$];
   comb_elem_type       oldest_elem;

   value_type           multiset_vals [MAX_SET];
   value_type           comb_vals [MAX_SET];
   int unsigned         comb_len;
   bit                  enum_over;
   logic [SZ_BITS-1:0]  set_size_reg;
   logic [SZ_BITS-1:0]  comb_size_reg;
   logic                all_sizes_reg;

   function automatic void queue_elem(value_type v, int unsigned pos, logic l, logic d);
      comb_elem_type e;
      e.value     = v;
      e.position  = POS_BITS'(pos);
      e.last      = l;
      e.done      = d;
      comb_elem_q = {comb_elem_q, e};
   endfunction

   function automatic void finish_enum();
      enum_over = 1'b1;
      queue_elem('0, 0, 1'b1, 1'b1);
   endfunction

   function automatic void emit_combination();
      for (int unsigned i = 0; i < comb_len; i++)
         queue_elem(comb_vals[i], i, (i + 1 == comb_len), 1'b0);
   endfunction

   // first combination of a size is the head of the sorted set
   function automatic void open_size(int unsigned size, int unsigned s);
      if (size == 0 || size > s) begin
         finish_enum();
      end else begin
         for (int unsigned i = 0; i < size; i++)
            comb_vals[i] = multiset_vals[i];
         comb_len = size;
         emit_combination();
      end
   endfunction

   function automatic void step_combination();
      int unsigned s, k, ci, si, ni, lo, hi, mid;
      value_type   pivot;
      s = (set_size_reg > SET_CAP) ? SET_CAP : set_size_reg;
      if (enum_over) begin
         finish_enum();
      end else if (comb_len == 0) begin
         open_size(all_sizes_reg ? 1 : comb_size_reg, s);
      end else if (comb_len > s) begin
         finish_enum();
      end else begin
         k  = comb_len;
         ci = k;
         si = s;
         // skip the tail that already sits on the top of the set
         while (ci > 0 && comb_vals[ci-1] == multiset_vals[si-1]) begin
            ci--;
            si--;
         end
         if (ci == 0) begin
            if (all_sizes_reg && k < s) open_size(k + 1, s);
            else finish_enum();
         end else begin
            ci--;
            pivot = comb_vals[ci];
            lo = 0;
            hi = s;
            while (lo < hi) begin
               mid = (lo + hi) / 2;
               if (multiset_vals[mid] <= pivot) lo = mid + 1;
               else hi = mid;
            end
            ni = lo;
            if (ni + (k - ci) > s) begin
               finish_enum();
            end else begin
               for (; ci < k; ci++) begin
                  comb_vals[ci] = multiset_vals[ni];
                  ni++;
               end
               emit_combination();
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         comb_elem_q.delete();
         foreach (multiset_vals[i]) begin
            multiset_vals[i] = '0;
            comb_vals[i]     = '0;
         end
         comb_len      = 0;
         enum_over     = 1'b0;
         set_size_reg  = SET_SIZE_RST;
         comb_size_reg = COMB_SIZE_RST;
         all_sizes_reg = 1'b0;
         fail_count    = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_SIZE:  set_size_reg  = csr_wdata;
               CSR_COMB_SIZE: comb_size_reg = csr_wdata;
               CSR_ALL_SIZES: all_sizes_reg = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (comb_elem_q.size() == 0) begin
               $display("%0t: unexpected result: value=%h pos=%0d last=%b done=%b",
                        $time, rsp_out_value, rsp_out_position, rsp_last, rsp_done_res);
               fail_count++;
            end else begin
               oldest_elem = comb_elem_q.pop_front();
               if (oldest_elem.value !== rsp_out_value ||
                   oldest_elem.position !== rsp_out_position ||
                   oldest_elem.last !== rsp_last ||
                   oldest_elem.done !== rsp_done_res) begin
                  // fields: value/position/last/done
                  $display("%0t: result mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                           $time, oldest_elem.value, oldest_elem.position,
                           oldest_elem.last, oldest_elem.done, rsp_out_value,
                           rsp_out_position, rsp_last, rsp_done_res);
                  fail_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_type)
               REQ_LOAD: multiset_vals[req_elem_index] = req_elem_value;
               REQ_RESTART: begin
                  comb_len  = 0;
                  enum_over = 1'b0;
               end
               REQ_NEXT: step_combination();
               default: ;
            endcase
         end
      end
      pending_count = comb_elem_q.size();
   end

endmodule

// ===== tb/tb_multiset_combination_generator_core.sv =====
module tb_multiset_combination_generator_core;
   import mcg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [REQ_BITS-1:0]     REQ_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE   = 2'd3;
   localparam int                      STALL_LIMIT = 4000;
   localparam int                      RANDOM_ITEMS = 320;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   bit                       no_gaps;
   int                       fail_count;
   int                       pending_count;
   int unsigned              sent_items;
   int unsigned              filled_count;
   int                       idle_cycles;

   mcg_req_if req_ch ();
   mcg_rsp_if rsp_ch ();

   multiset_combination_generator_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mcg_comb_checker comb_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_type         (req_ch.req_type),
      .req_elem_index   (req_ch.elem_index),
      .req_elem_value   (req_ch.elem_value),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_value    (rsp_ch.out_value),
      .rsp_out_position (rsp_ch.out_position),
      .rsp_last         (rsp_ch.last),
      .rsp_done_res     (rsp_ch.done_res),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 25);
   end

   // end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called and returns at a falling edge; valid stays high for a follow-on transaction
   task automatic send_req(input logic [REQ_BITS-1:0] kind,
                           input logic [ELEM_IDX_BITS-1:0] idx,
                           input value_type val);
      while (!no_gaps && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.elem_index <= idx;
      req_ch.elem_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (kind != REQ_UNUSED) sent_items++;
      @(negedge clock);
   endtask

   task automatic drain(input int unsigned settle);
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic configure(input logic [SZ_BITS-1:0] set_sz,
                            input logic [SZ_BITS-1:0] comb_sz,
                            input logic all_sz);
      logic [CSR_DATA_BITS-1:0] flag_word;
      flag_word    = CSR_DATA_BITS'($urandom);
      flag_word[0] = all_sz;
      write_reg(CSR_SET_SIZE, set_sz);
      write_reg(CSR_COMB_SIZE, comb_sz);
      write_reg(CSR_ALL_SIZES, flag_word);
      csr_wr_en <= 1'b0;
   endtask

   // sorted set drawn from a small pool so duplicates are common
   task automatic load_sorted(input int unsigned count);
      value_type   pool[$];
      value_type   picks[$];
      value_type   cand;
      int unsigned width;
      if (count != 0) begin
         width = $urandom_range(1, count);
         repeat (width) begin
            case ($urandom_range(9))
               0:       cand = {VALUE_BITS{1'b0}};
               1:       cand = {VALUE_BITS{1'b1}};
               default: cand = value_type'($urandom);
            endcase
            pool = {pool, cand};
         end
         repeat (count) picks = {picks, pool[$urandom_range(0, width - 1)]};
         picks.sort();
         foreach (picks[i]) send_req(REQ_LOAD, ELEM_IDX_BITS'(i), picks[i]);
         if (count > filled_count) filled_count = count;
      end
   endtask

   initial begin
      logic [SZ_BITS-1:0] set_pick;
      logic [SZ_BITS-1:0] comb_pick;
      logic               all_pick;
      int unsigned        s, n, phase, pick;
      bit                 fresh;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = REQ_LOAD;
      req_ch.elem_index    = '0;
      req_ch.elem_value    = '0;
      no_gaps              = 1'b0;
      sent_items           = 0;
      filled_count         = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: set of four with duplicates, pairs, exhaustion and size corner cases
      write_reg(CSR_SPARE, '1);
      configure(5'd4, 5'd2, 1'b0);
      send_req(REQ_UNUSED, '1, '1);
      send_req(REQ_LOAD, 4'd0, 16'h0000);
      send_req(REQ_LOAD, 4'd1, 16'h0000);
      send_req(REQ_LOAD, 4'd2, 16'h5A5A);
      send_req(REQ_LOAD, 4'd3, 16'hFFFF);
      filled_count = 4;
      repeat (6) send_req(REQ_NEXT, '0, '0);
      send_req(REQ_RESTART, '0, '0);
      send_req(REQ_NEXT, '0, '0);
      send_req(REQ_NEXT, '0, '0);
      // shrink the set under a running enumeration
      drain(8);
      configure(5'd1, 5'd2, 1'b0);
      send_req(REQ_NEXT, '0, '0);
      drain(8);
      configure(5'd4, 5'd0, 1'b0);
      send_req(REQ_RESTART, '0, '0);
      send_req(REQ_NEXT, '0, '0);
      drain(8);
      configure(5'd4, 5'd5, 1'b0);
      send_req(REQ_RESTART, '0, '0);
      send_req(REQ_NEXT, '0, '0);

      sent_items = 0;
      phase      = 0;
      while (sent_items < RANDOM_ITEMS) begin
         drain(8);
         no_gaps = (phase >= 5 && phase <= 7);
         case (phase)
            0: begin set_pick = 5'd16; comb_pick = 5'd16; all_pick = 1'b0; end
            1: begin set_pick = 5'd31; comb_pick = 5'd31; all_pick = 1'b1; end
            2: begin set_pick = 5'd0;  comb_pick = 5'd1;  all_pick = 1'b1; end
            3: begin set_pick = 5'd17; comb_pick = 5'd15; all_pick = 1'b0; end
            default: begin
               pick = $urandom_range(99);
               if (pick < 80) set_pick = SZ_BITS'($urandom_range(1, 6));
               else if (pick < 90) set_pick = SZ_BITS'($urandom_range(7, 16));
               else set_pick = SZ_BITS'($urandom_range(0, 31));
               s = (set_pick > SET_CAP) ? SET_CAP : set_pick;
               if (s > 0 && $urandom_range(99) < 75)
                  comb_pick = SZ_BITS'($urandom_range(1, s));
               else
                  comb_pick = SZ_BITS'($urandom_range(0, 31));
               all_pick = ($urandom_range(99) < 30);
            end
         endcase
         configure(set_pick, comb_pick, all_pick);
         s = (set_pick > SET_CAP) ? SET_CAP : set_pick;

         // never let a next read an entry that was never loaded
         fresh = (s > filled_count) || ($urandom_range(9) < 8);
         if (fresh) load_sorted(s);
         if (fresh || $urandom_range(4) != 0)
            send_req(REQ_RESTART, ELEM_IDX_BITS'($urandom), value_type'($urandom));

         n = $urandom_range(1, 30);
         repeat (n) begin
            if ($urandom_range(99) < 4) drain(1);
            if ($urandom_range(99) < 10)
               send_req(REQ_BITS'($urandom), ELEM_IDX_BITS'($urandom),
                        value_type'($urandom));
            else
               send_req(REQ_NEXT, ELEM_IDX_BITS'($urandom), value_type'($urandom));
         end
         phase++;
      end

      drain(64);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mcg_pkg.sv
sv/mcg_if.sv
sv/mcg_cell.sv
sv/multiset_combination_generator_core.sv
tb/mcg_comb_checker.sv
tb/tb_multiset_combination_generator_core.sv
